### src/tfc_pkg.sv
package tfc_pkg;

    // Default image size limits
    localparam int TFC_MAX_WIDTH  = 4096;
    localparam int TFC_MAX_HEIGHT = 4096;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int SIZE_W      = 13;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_SOURCE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAD_ROWS       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd4;

    // Single byte channel sources; other codes give a zero byte
    localparam logic [2:0] SRC_RED   = 3'd0;
    localparam logic [2:0] SRC_GREEN = 3'd1;
    localparam logic [2:0] SRC_BLUE  = 3'd2;
    localparam logic [2:0] SRC_AVG   = 3'd3;
    localparam logic [2:0] SRC_ALPHA = 3'd4;

    // Reset values of the configuration registers
    localparam logic [2:0]        RST_CHANNEL_SOURCE = SRC_AVG;
    localparam logic              RST_PAD_ROWS       = 1'b1;
    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH    = 13'd256;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT   = 13'd256;

    // Byte counts
    localparam logic [2:0] BYTES_ONE  = 3'd1;
    localparam logic [2:0] BYTES_TWO  = 3'd2;
    localparam logic [2:0] BYTES_FOUR = 3'd4;

    // Reciprocal of three for the channel average: floor(s * 683 / 2048)
    localparam logic [19:0] RECIP3_MUL   = 20'd683;
    localparam int          RECIP3_SHIFT = 11;

    typedef enum logic [2:0] {
        MODE_PASS        = 3'd0,
        MODE_RGB565      = 3'd1,
        MODE_RGBA4444    = 3'd2,
        MODE_RGBA5551    = 3'd3,
        MODE_TO_BYTE     = 3'd4,
        MODE_BYTE_ALIGN  = 3'd5,
        MODE_RG_ALIGN    = 3'd6,
        MODE_TO_RG       = 3'd7
    } mode_t;

    // Converted texel and the padding it needs at a row end
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  bytes;
        logic [2:0]  pad_bytes;
    } conv_t;

    // Image position status for the texel at hand
    typedef struct packed {
        logic       row_end;
        logic       img_end;
        logic [1:0] width_low;
    } pos_t;

endpackage

### src/tfc_if.sv
// Input texel stream
interface tfc_texel_if;
    logic        valid;
    logic        ready;
    logic [31:0] texel_word;

    modport source (output valid, output texel_word, input ready);
    modport sink   (input valid, input texel_word, output ready);
endinterface

// Converted result stream
interface tfc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_data;
    logic [2:0]  byte_count;
    logic        is_padding;
    logic        end_of_image;
    logic        last_of_run;

    modport source (output valid, output out_data, output byte_count, output is_padding,
                    output end_of_image, output last_of_run, input ready);
    modport sink   (input valid, input out_data, input byte_count, input is_padding,
                    input end_of_image, input last_of_run, output ready);
endinterface

### src/texel_format_converter.sv
// Path: a texel beat is captured in the input register, then moved into the result register.
// Throughput: one texel per cycle while the receiver is ready; a row that ends with a padding
// result stalls the input while the result register holds the texel and padding results in turn.
// Reset: rst_n clears the column and row counters and the pipeline valid bits, and sets
// the configuration to pass-through, average source, row padding on and a 256 x 256 image.
module texel_format_converter #(
    parameter int MAX_WIDTH  = tfc_pkg::TFC_MAX_WIDTH,
    parameter int MAX_HEIGHT = tfc_pkg::TFC_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    tfc_texel_if.sink                       texel_in,
    tfc_result_if.source                    result_out
);
    import tfc_pkg::*;

    // Configuration registers
    mode_t             format_mode_reg;
    logic [2:0]        channel_source_reg;
    logic              pad_rows_reg;
    logic [SIZE_W-1:0] image_width_reg;
    logic [SIZE_W-1:0] image_height_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_word_reg;

    // Result register: the texel result and the padding result behind it
    logic        main_valid_reg;
    logic        main_valid_next;
    logic        pad_valid_reg;
    logic        pad_valid_next;
    logic [31:0] main_data_reg;
    logic [2:0]  main_bytes_reg;
    logic        main_eoi_reg;
    logic        main_last_reg;
    logic [2:0]  pad_bytes_reg;
    logic        pad_eoi_reg;

    conv_t conv;
    pos_t  pos;
    logic  in_beat;
    logic  out_beat;
    logic  result_free;
    logic  advance;
    logic  has_pad;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg    <= MODE_PASS;
            channel_source_reg <= RST_CHANNEL_SOURCE;
            pad_rows_reg       <= RST_PAD_ROWS;
            image_width_reg    <= RST_IMAGE_WIDTH;
            image_height_reg   <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FORMAT_MODE:    format_mode_reg    <= mode_t'(cfg_data[2:0]);
                CFG_CHANNEL_SOURCE: channel_source_reg <= cfg_data[2:0];
                CFG_PAD_ROWS:       pad_rows_reg       <= cfg_data[0];
                CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data[SIZE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Handshake: the input register moves on once the result register will be empty
    assign out_beat    = result_out.valid && result_out.ready;
    assign result_free = (!main_valid_reg && !pad_valid_reg) ||
                         (result_out.ready && (main_valid_reg ^ pad_valid_reg));
    assign advance     = in_valid_reg && result_free;
    assign texel_in.ready = !in_valid_reg || advance;
    assign in_beat     = texel_in.valid && texel_in.ready;

    tfc_convert u_convert (
        .texel_word     (in_word_reg),
        .format_mode    (format_mode_reg),
        .channel_source (channel_source_reg),
        .pad_rows       (pad_rows_reg),
        .width_low      (pos.width_low),
        .conv           (conv)
    );

    tfc_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .advance      (advance),
        .pos          (pos)
    );

    assign has_pad = pos.row_end && (conv.pad_bytes != 3'd0);

    // Valid bits of the input and result registers
    always_comb
    begin
        in_valid_next   = in_valid_reg;
        main_valid_next = main_valid_reg;
        pad_valid_next  = pad_valid_reg;
        if (in_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (advance)
        begin
            main_valid_next = 1'b1;
            pad_valid_next  = has_pad;
        end
        else if (out_beat)
        begin
            if (main_valid_reg)
            begin
                main_valid_next = 1'b0;
            end
            else
            begin
                pad_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            main_valid_reg <= 1'b0;
            pad_valid_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            main_valid_reg <= main_valid_next;
            pad_valid_reg  <= pad_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_word_reg <= texel_in.texel_word;
        end
        if (advance)
        begin
            main_data_reg  <= conv.data;
            main_bytes_reg <= conv.bytes;
            main_eoi_reg   <= pos.img_end && !has_pad;
            main_last_reg  <= !has_pad;
            pad_bytes_reg  <= conv.pad_bytes;
            pad_eoi_reg    <= pos.img_end;
        end
    end

    // Present the texel result first, then the padding result
    assign result_out.valid        = main_valid_reg || pad_valid_reg;
    assign result_out.out_data     = main_valid_reg ? main_data_reg : 32'd0;
    assign result_out.byte_count   = main_valid_reg ? main_bytes_reg : pad_bytes_reg;
    assign result_out.is_padding   = !main_valid_reg;
    assign result_out.end_of_image = main_valid_reg ? main_eoi_reg : pad_eoi_reg;
    assign result_out.last_of_run  = main_valid_reg ? main_last_reg : 1'b1;

    // A padding result is always zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.is_padding |-> result_out.out_data == 32'd0)
        else $error("padding result carries nonzero data");

    // A result that does not close its run must have a padding result waiting behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && !result_out.last_of_run |-> pad_valid_reg)
        else $error("open run without a pending padding result");

    // The end of the image is only flagged on the last result of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.end_of_image |-> result_out.last_of_run)
        else $error("end of image flagged before the run is complete");

    // A texel moved out of the input register shows up as a texel result next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> main_valid_reg)
        else $error("converted texel lost on its way to the result register");

endmodule

### src/tfc_convert.sv
module tfc_convert (
    input  logic [31:0]    texel_word,
    input  tfc_pkg::mode_t format_mode,
    input  logic [2:0]     channel_source,
    input  logic           pad_rows,
    input  logic [1:0]     width_low,
    output tfc_pkg::conv_t conv
);
    import tfc_pkg::*;

    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [9:0]  rgb_sum;
    logic [19:0] avg_prod;
    logic [7:0]  avg;
    logic [7:0]  single;

    assign red   = texel_word[7:0];
    assign green = texel_word[15:8];
    assign blue  = texel_word[23:16];
    assign alpha = texel_word[31:24];

    // Average of the color channels, divided by three through a reciprocal multiply
    assign rgb_sum  = 10'(red) + 10'(green) + 10'(blue);
    assign avg_prod = 20'(rgb_sum) * RECIP3_MUL;
    assign avg      = avg_prod[RECIP3_SHIFT +: 8];

    // Single byte channel selection
    always_comb
    begin
        unique case (channel_source)
            SRC_RED:   single = red;
            SRC_GREEN: single = green;
            SRC_BLUE:  single = blue;
            SRC_AVG:   single = avg;
            SRC_ALPHA: single = alpha;
            default:   single = 8'd0;
        endcase
    end

    // Format conversion and row padding amount
    always_comb
    begin
        conv.pad_bytes = 3'd0;
        unique case (format_mode)
            MODE_PASS:
            begin
                conv.data  = texel_word;
                conv.bytes = BYTES_FOUR;
            end
            MODE_RGB565:
            begin
                conv.data  = {16'd0, red[7:3], green[7:2], blue[7:3]};
                conv.bytes = BYTES_TWO;
            end
            MODE_RGBA4444:
            begin
                conv.data  = {16'd0, red[7:4], green[7:4], blue[7:4], alpha[7:4]};
                conv.bytes = BYTES_TWO;
            end
            MODE_RGBA5551:
            begin
                conv.data  = {16'd0, red[7:3], green[7:3], blue[7:3], alpha[7]};
                conv.bytes = BYTES_TWO;
            end
            MODE_TO_BYTE:
            begin
                conv.data  = {24'd0, single};
                conv.bytes = BYTES_ONE;
            end
            MODE_BYTE_ALIGN:
            begin
                // Pad the row up to a multiple of four bytes.
                conv.data      = {24'd0, red};
                conv.bytes     = BYTES_ONE;
                conv.pad_bytes = {1'b0, 2'(~width_low + 2'd1)};
            end
            MODE_RG_ALIGN:
            begin
                conv.data      = {16'd0, texel_word[15:0]};
                conv.bytes     = BYTES_TWO;
                conv.pad_bytes = width_low[0] ? BYTES_TWO : 3'd0;
            end
            MODE_TO_RG:
            begin
                conv.data      = {16'd0, texel_word[15:0]};
                conv.bytes     = BYTES_TWO;
                conv.pad_bytes = (width_low[0] && pad_rows) ? BYTES_TWO : 3'd0;
            end
        endcase
    end

endmodule

### src/tfc_position.sv
module tfc_position #(
    parameter int MAX_WIDTH  = tfc_pkg::TFC_MAX_WIDTH,
    parameter int MAX_HEIGHT = tfc_pkg::TFC_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [tfc_pkg::SIZE_W-1:0] image_width,
    input  logic [tfc_pkg::SIZE_W-1:0] image_height,
    input  logic                       advance,
    output tfc_pkg::pos_t              pos
);
    import tfc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [31:0]   width_wide;
    logic [31:0]   height_wide;
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;
    logic [WW:0]   col_inc;
    logic [HW:0]   row_inc;

    // Clamp the image size: zero acts as one, above the maximum acts as the maximum
    assign width_wide  = (image_width == '0) ? 32'd1 :
                         (32'(image_width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) :
                         32'(image_width);
    assign height_wide = (image_height == '0) ? 32'd1 :
                         (32'(image_height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) :
                         32'(image_height);
    assign width_eff   = width_wide[WW-1:0];
    assign height_eff  = height_wide[HW-1:0];

    // Row and image end detection
    assign col_inc       = (WW+1)'(col_reg) + (WW+1)'(1);
    assign row_inc       = (HW+1)'(row_reg) + (HW+1)'(1);
    assign pos.row_end   = col_inc >= {1'b0, width_eff};
    assign pos.img_end   = pos.row_end && (row_inc >= {1'b0, height_eff});
    assign pos.width_low = width_eff[1:0];

    // Counter update for each converted texel
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (pos.row_end)
            begin
                col_next = '0;
                row_next = pos.img_end ? '0 : row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### bench/tb_texel_format_converter.sv
module tb_texel_format_converter;
    import tfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned TAIL_CYCLES  = 16;
    localparam int unsigned LONG_ROW     = 255;

    // Channel source codes that select nothing and give a zero byte.
    localparam logic [2:0] SRC_UNUSED_LO = 3'd5;
    localparam logic [2:0] SRC_UNUSED_HI = 3'd7;

    // One converted beat as it should leave the block.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  bytes;
        logic        padding;
        logic        image_end;
        logic        run_end;
    } result_beat_t;

    // One texel to send, with an optional hand-typed first result.
    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        logic [31:0] data;
        logic [2:0]  bytes;
    } texel_job_t;

    typedef struct {
        mode_t             mode;
        logic [2:0]        source;
        logic              pad;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [31:0]       word;
        logic              typed;
        logic [31:0]       data;
        logic [2:0]        bytes;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tfc_texel_if  texel_bus ();
    tfc_result_if result_bus ();

    texel_format_converter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .texel_in   (texel_bus),
        .result_out (result_bus)
    );

    // Local copy of the configuration and of the image position.
    mode_t             fmt_mode;
    logic [2:0]        chan_src;
    logic              pad_odd_rows;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    int unsigned       column_pos;
    int unsigned       row_pos;

    texel_job_t   texel_queue[$];
    result_beat_t converted_beats[$];

    int unsigned idle_pct = 10;
    bit          hold_request;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    logic [SIZE_W-1:0] extreme_sizes [4] = '{13'd0, 13'd1, 13'd4096, 13'h1FFF};

    // Directed texels: typed results where the conversion is obvious.
    directed_row_t directed_rows [24] = '{
        '{MODE_PASS,       SRC_AVG,       1'b1, 13'd256, 13'd256, 32'hFFFFFFFF,
          1'b1, 32'hFFFFFFFF, BYTES_FOUR},
        '{MODE_PASS,       SRC_AVG,       1'b1, 13'd256, 13'd256, 32'h00000000,
          1'b1, 32'h00000000, BYTES_FOUR},
        '{MODE_RGB565,     SRC_AVG,       1'b1, 13'd1,   13'd1,   32'hFFFFFFFF,
          1'b1, 32'h0000FFFF, BYTES_TWO},
        '{MODE_RGB565,     SRC_AVG,       1'b1, 13'd1,   13'd1,   32'h00000000,
          1'b1, 32'h00000000, BYTES_TWO},
        '{MODE_RGBA4444,   SRC_AVG,       1'b1, 13'd1,   13'd1,   32'hFFFFFFFF,
          1'b1, 32'h0000FFFF, BYTES_TWO},
        '{MODE_RGBA4444,   SRC_AVG,       1'b1, 13'd1,   13'd1,   32'h12345678,
          1'b1, 32'h00007531, BYTES_TWO},
        '{MODE_RGBA5551,   SRC_AVG,       1'b1, 13'd1,   13'd1,   32'hFFFFFFFF,
          1'b1, 32'h0000FFFF, BYTES_TWO},
        '{MODE_RGBA5551,   SRC_AVG,       1'b1, 13'd1,   13'd1,   32'h80000000,
          1'b1, 32'h00000001, BYTES_TWO},
        '{MODE_TO_BYTE,    SRC_RED,       1'b1, 13'd1,   13'd1,   32'h000000AB,
          1'b1, 32'h000000AB, BYTES_ONE},
        '{MODE_TO_BYTE,    SRC_GREEN,     1'b1, 13'd1,   13'd1,   32'h0000CD00,
          1'b1, 32'h000000CD, BYTES_ONE},
        '{MODE_TO_BYTE,    SRC_BLUE,      1'b1, 13'd1,   13'd1,   32'h00EF0000,
          1'b1, 32'h000000EF, BYTES_ONE},
        '{MODE_TO_BYTE,    SRC_AVG,       1'b1, 13'd1,   13'd1,   32'h00FFFFFF,
          1'b1, 32'h000000FF, BYTES_ONE},
        '{MODE_TO_BYTE,    SRC_AVG,       1'b1, 13'd1,   13'd1,   32'hFF010203,
          1'b1, 32'h00000002, BYTES_ONE},
        '{MODE_TO_BYTE,    SRC_ALPHA,     1'b1, 13'd1,   13'd1,   32'h9A000000,
          1'b1, 32'h0000009A, BYTES_ONE},
        '{MODE_TO_BYTE,    SRC_UNUSED_LO, 1'b1, 13'd1,   13'd1,   32'hFFFFFFFF,
          1'b1, 32'h00000000, BYTES_ONE},
        '{MODE_TO_BYTE,    SRC_UNUSED_HI, 1'b1, 13'd1,   13'd1,   32'hFFFFFFFF,
          1'b1, 32'h00000000, BYTES_ONE},
        '{MODE_BYTE_ALIGN, SRC_UNUSED_HI, 1'b1, 13'd3,   13'd2,   32'hAAAAAA5A,
          1'b0, 32'h0, BYTES_ONE},
        '{MODE_BYTE_ALIGN, SRC_UNUSED_HI, 1'b1, 13'd3,   13'd2,   32'h555555A5,
          1'b0, 32'h0, BYTES_ONE},
        '{MODE_BYTE_ALIGN, SRC_UNUSED_HI, 1'b1, 13'd3,   13'd2,   32'hFFFFFFFF,
          1'b0, 32'h0, BYTES_ONE},
        '{MODE_RG_ALIGN,   SRC_UNUSED_HI, 1'b1, 13'd1,   13'd1,   32'hFFFFFFFF,
          1'b1, 32'h0000FFFF, BYTES_TWO},
        '{MODE_TO_RG,      SRC_UNUSED_HI, 1'b1, 13'd1,   13'd1,   32'h0000ABCD,
          1'b1, 32'h0000ABCD, BYTES_TWO},
        '{MODE_TO_RG,      SRC_UNUSED_HI, 1'b0, 13'd1,   13'd1,   32'hFFFF1234,
          1'b1, 32'h00001234, BYTES_TWO},
        '{MODE_PASS,       SRC_UNUSED_HI, 1'b0, 13'd0,   13'd0,   32'h13579BDF,
          1'b0, 32'h0, BYTES_FOUR},
        '{MODE_PASS,       SRC_UNUSED_HI, 1'b0, 13'h1FFF, 13'd5000, 32'h2468ACE0,
          1'b0, 32'h0, BYTES_FOUR}
    };

    // Free-running clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Cycle counter with a hard stop for a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // A zero size acts as one, an oversized one as the maximum.
    function automatic int unsigned effective_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        if (v == '0)
            return 1;
        if (32'(v) > maxv)
            return maxv;
        return 32'(v);
    endfunction

    // Convert one accepted texel, queue its beats and step the image position.
    task automatic convert_texel(input texel_job_t job);
        int unsigned  eff_width;
        int unsigned  eff_height;
        int unsigned  pad_bytes;
        int unsigned  channel_sum;
        logic [7:0]   r;
        logic [7:0]   g;
        logic [7:0]   b;
        logic [7:0]   a;
        logic         row_end;
        logic         img_end;
        result_beat_t texel_beat;
        result_beat_t pad_beat;

        eff_width  = effective_size(width_reg, TFC_MAX_WIDTH);
        eff_height = effective_size(height_reg, TFC_MAX_HEIGHT);
        {a, b, g, r} = job.word;
        pad_bytes  = 0;
        texel_beat = '0;

        case (fmt_mode)
            MODE_PASS:
            begin
                texel_beat.data  = job.word;
                texel_beat.bytes = BYTES_FOUR;
            end
            MODE_RGB565:
            begin
                texel_beat.data  = {16'h0, r[7:3], g[7:2], b[7:3]};
                texel_beat.bytes = BYTES_TWO;
            end
            MODE_RGBA4444:
            begin
                texel_beat.data  = {16'h0, r[7:4], g[7:4], b[7:4], a[7:4]};
                texel_beat.bytes = BYTES_TWO;
            end
            MODE_RGBA5551:
            begin
                texel_beat.data  = {16'h0, r[7:3], g[7:3], b[7:3], a[7]};
                texel_beat.bytes = BYTES_TWO;
            end
            MODE_TO_BYTE:
            begin
                channel_sum = 32'(r) + 32'(g) + 32'(b);
                case (chan_src)
                    SRC_RED:   texel_beat.data = {24'h0, r};
                    SRC_GREEN: texel_beat.data = {24'h0, g};
                    SRC_BLUE:  texel_beat.data = {24'h0, b};
                    SRC_AVG:   texel_beat.data = channel_sum / 3;
                    SRC_ALPHA: texel_beat.data = {24'h0, a};
                    default:   texel_beat.data = '0;
                endcase
                texel_beat.bytes = BYTES_ONE;
            end
            MODE_BYTE_ALIGN:
            begin
                texel_beat.data  = {24'h0, r};
                texel_beat.bytes = BYTES_ONE;
                pad_bytes        = (4 - (eff_width & 3)) & 3;
            end
            MODE_RG_ALIGN:
            begin
                texel_beat.data  = {16'h0, job.word[15:0]};
                texel_beat.bytes = BYTES_TWO;
                pad_bytes        = eff_width[0] ? 2 : 0;
            end
            default:
            begin
                texel_beat.data  = {16'h0, job.word[15:0]};
                texel_beat.bytes = BYTES_TWO;
                pad_bytes        = (eff_width[0] && pad_odd_rows) ? 2 : 0;
            end
        endcase

        // Hand-typed rows replace the computed texel value.
        if (job.typed)
        begin
            texel_beat.data  = job.data;
            texel_beat.bytes = job.bytes;
        end

        row_end = (column_pos + 1 >= eff_width);
        img_end = row_end && (row_pos + 1 >= eff_height);

        if (row_end && pad_bytes != 0)
        begin
            pad_beat           = '0;
            pad_beat.bytes     = 3'(pad_bytes);
            pad_beat.padding   = 1'b1;
            pad_beat.image_end = img_end;
            pad_beat.run_end   = 1'b1;
            converted_beats.push_back(texel_beat);
            converted_beats.push_back(pad_beat);
        end
        else
        begin
            texel_beat.image_end = img_end;
            texel_beat.run_end   = 1'b1;
            converted_beats.push_back(texel_beat);
        end

        if (row_end)
        begin
            column_pos = 0;
            row_pos    = img_end ? 0 : row_pos + 1;
        end
        else
            column_pos = column_pos + 1;
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Texel sender: offers queued texels, idles at random, never drops an offer.
    initial
    begin
        texel_bus.valid      = 1'b0;
        texel_bus.texel_word = '0;
        forever
        begin
            @(posedge clk);
            if (texel_bus.valid && texel_bus.ready)
            begin
                convert_texel(texel_queue[0]);
                void'(texel_queue.pop_front());
            end
            if (!(texel_bus.valid && !texel_bus.ready))
            begin
                if (texel_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    texel_bus.valid      <= 1'b1;
                    texel_bus.texel_word <= texel_queue[0].word;
                end
                else
                    texel_bus.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int unsigned hold_left;

        hold_left        = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compare every result beat with the oldest converted beat.
    always @(posedge clk)
    begin
        result_beat_t want;

        if (result_bus.valid && result_bus.ready)
        begin
            if (converted_beats.size() == 0)
                report_mismatch($sformatf("unexpected result beat, data %h",
                                          result_bus.out_data));
            else
            begin
                want = converted_beats.pop_front();
                if (result_bus.out_data !== want.data)
                    report_mismatch($sformatf("out_data %h, want %h",
                                              result_bus.out_data, want.data));
                if (result_bus.byte_count !== want.bytes)
                    report_mismatch($sformatf("byte_count %0d, want %0d",
                                              result_bus.byte_count, want.bytes));
                if (result_bus.is_padding !== want.padding)
                    report_mismatch($sformatf("is_padding %b, want %b",
                                              result_bus.is_padding, want.padding));
                if (result_bus.end_of_image !== want.image_end)
                    report_mismatch($sformatf("end_of_image %b, want %b",
                                              result_bus.end_of_image, want.image_end));
                if (result_bus.last_of_run !== want.run_end)
                    report_mismatch($sformatf("last_of_run %b, want %b",
                                              result_bus.last_of_run, want.run_end));
            end
        end
    end

    task automatic wait_results_drained();
        do
            @(negedge clk);
        while (texel_queue.size() != 0 || converted_beats.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
    endtask

    // Write the registers that differ from the current setting; block must be idle.
    task automatic apply_config(input mode_t mode, input logic [2:0] source,
                                input logic pad, input logic [SIZE_W-1:0] width,
                                input logic [SIZE_W-1:0] height);
        bit wrote;

        wrote = 1'b0;
        if (mode != fmt_mode)
        begin
            write_reg(CFG_FORMAT_MODE, CFG_DATA_W'(mode));
            fmt_mode = mode;
            wrote    = 1'b1;
        end
        if (source != chan_src)
        begin
            write_reg(CFG_CHANNEL_SOURCE, CFG_DATA_W'(source));
            chan_src = source;
            wrote    = 1'b1;
        end
        if (pad != pad_odd_rows)
        begin
            write_reg(CFG_PAD_ROWS, CFG_DATA_W'(pad));
            pad_odd_rows = pad;
            wrote        = 1'b1;
        end
        if (width != width_reg)
        begin
            write_reg(CFG_IMAGE_WIDTH, width);
            width_reg = width;
            wrote     = 1'b1;
        end
        if (height != height_reg)
        begin
            write_reg(CFG_IMAGE_HEIGHT, height);
            height_reg = height;
            wrote      = 1'b1;
        end
        if (wrote)
        begin
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Reset, directed texels, then random phases under changing settings.
    initial
    begin
        texel_job_t        job;
        mode_t             phase_mode;
        logic [2:0]        phase_source;
        logic              phase_pad;
        logic [SIZE_W-1:0] phase_width;
        logic [SIZE_W-1:0] phase_height;
        int unsigned       phase_items;
        int unsigned       phase_index;
        int unsigned       random_items;
        int unsigned       pick;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FORMAT_MODE;
        cfg_data     = '0;
        fmt_mode     = MODE_PASS;
        chan_src     = RST_CHANNEL_SOURCE;
        pad_odd_rows = RST_PAD_ROWS;
        width_reg    = RST_IMAGE_WIDTH;
        height_reg   = RST_IMAGE_HEIGHT;
        column_pos   = 0;
        row_pos      = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: settings change only once earlier texels are done.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].mode != fmt_mode || directed_rows[i].source != chan_src ||
                directed_rows[i].pad != pad_odd_rows ||
                directed_rows[i].width != width_reg || directed_rows[i].height != height_reg)
            begin
                wait_results_drained();
                apply_config(directed_rows[i].mode, directed_rows[i].source,
                             directed_rows[i].pad, directed_rows[i].width,
                             directed_rows[i].height);
            end
            job.word  = directed_rows[i].word;
            job.typed = directed_rows[i].typed;
            job.data  = directed_rows[i].data;
            job.bytes = directed_rows[i].bytes;
            @(negedge clk);
            texel_queue.push_back(job);
        end
        wait_results_drained();

        // Random phases: mostly small images, now and then extreme sizes.
        random_items = 0;
        phase_index  = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase_mode   = mode_t'($urandom_range(0, 7));
            phase_source = 3'($urandom_range(0, 7));
            phase_pad    = 1'($urandom_range(0, 1));
            if ($urandom_range(9) == 0)
                phase_width = extreme_sizes[$urandom_range(0, 3)];
            else
                phase_width = SIZE_W'($urandom_range(1, 9));
            if ($urandom_range(9) == 0)
                phase_height = extreme_sizes[$urandom_range(0, 3)];
            else
                phase_height = SIZE_W'($urandom_range(1, 4));
            phase_items = $urandom_range(8, 48);

            if (phase_index == 3 || phase_index == 6)
                phase_items = 200;
            if (phase_index == 9)
            begin
                // One long odd row with padding at the far end.
                phase_mode   = MODE_TO_RG;
                phase_pad    = 1'b1;
                phase_width  = SIZE_W'(LONG_ROW);
                phase_height = 13'd1;
                phase_items  = LONG_ROW + 3;
            end

            apply_config(phase_mode, phase_source, phase_pad, phase_width, phase_height);
            @(negedge clk);
            for (int k = 0; k < phase_items; k++)
            begin
                pick = $urandom_range(15);
                if (pick == 0)
                    job.word = 32'h00000000;
                else if (pick == 1)
                    job.word = 32'hFFFFFFFF;
                else
                    job.word = $urandom;
                job.typed = 1'b0;
                job.data  = '0;
                job.bytes = '0;
                texel_queue.push_back(job);
            end
            if (phase_index == 3)
                idle_pct = 0;
            if (phase_index == 6)
                hold_request = 1'b1;
            wait_results_drained();
            idle_pct = 10;

            random_items += phase_items;
            phase_index++;
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
